// ===== rtl/rtpl_pkg.sv =====
// ----------------------------------------------------------------------------
// rtpl_pkg
// Types, constants and helpers shared by the route table prefix lookup block.
// ----------------------------------------------------------------------------
package rtpl_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_LOOKUP = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_DONE     = 2'd0,
    STATUS_NO_ROUTE = 2'd1,
    STATUS_FULL     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_APPLY,
    ST_RESP
  } state_e;

  typedef struct packed {
    mode_e       mode;
    logic [31:0] address;
    logic [31:0] entry_mask;
    logic [31:0] entry_next_hop;
    logic [3:0]  entry_interface;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic        hit;
    logic        exact_hit;
    logic [31:0] found_dest;
    logic [31:0] found_mask;
    logic [31:0] found_next_hop;
    logic [3:0]  found_interface;
    logic [5:0]  found_prefix_length;
  } rsp_t;

  // One stored route; prefix length is computed once on insert.
  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] mask;
    logic [31:0] next_hop;
    logic [3:0]  itf;
    logic [5:0]  plen;
  } slot_t;

  // Table port commands from the controller.
  typedef struct packed {
    logic  rd_en;
    idx_t  rd_addr;
    logic  wr_en;
    idx_t  wr_addr;
    slot_t wr_data;
    logic  clr_en;
    idx_t  clr_addr;
    logic  clr_all;
  } tbl_cmd_t;

  // Registered read return from the table.
  typedef struct packed {
    logic  valid;
    idx_t  idx;
    logic  slot_valid;
    slot_t entry;
  } tbl_rd_t;

  // Scan results collected over one pass of the table.
  typedef struct packed {
    logic  exact_found;
    idx_t  exact_idx;
    slot_t exact_entry;
    logic  free_found;
    idx_t  free_idx;
    logic  best_found;
    slot_t best_entry;
  } scan_res_t;

  // Count of leading one bits: each width is checked on its own.
  function automatic logic [5:0] lead_ones(input logic [31:0] m);
    logic [5:0]  n;
    logic [31:0] top;
    n = 6'd0;
    for (int k = 1; k <= 32; k++) begin
      top = ~(32'hFFFF_FFFF >> k);
      if ((m & top) == top) begin
        n = 6'(k);
      end
    end
    return n;
  endfunction

endpackage

// ===== rtl/rtpl_table.sv =====
// ----------------------------------------------------------------------------
// rtpl_table
// Route storage: one synchronous slot memory plus a valid bit per slot.
// ----------------------------------------------------------------------------
module rtpl_table (
  input  logic               clk,
  input  logic               rst,
  input  rtpl_pkg::tbl_cmd_t cmd,
  output rtpl_pkg::tbl_rd_t  rd
);
  import rtpl_pkg::*;

  slot_t                    mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] slot_valid;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd.entry <= mem[cmd.rd_addr];
    end
    rd.idx        <= cmd.rd_addr;
    rd.slot_valid <= slot_valid[cmd.rd_addr];
    if (rst) begin
      rd.valid <= 1'b0;
    end else begin
      rd.valid <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else begin
      if (cmd.clr_all) begin
        slot_valid <= '0;
      end else begin
        if (cmd.wr_en) begin
          slot_valid[cmd.wr_addr] <= 1'b1;
        end
        if (cmd.clr_en) begin
          slot_valid[cmd.clr_addr] <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/rtpl_match.sv =====
// ----------------------------------------------------------------------------
// rtpl_match
// Per-slot compare unit: tracks exact key hit, lowest free slot and the
// best prefix match while the table streams past one slot a cycle.
// ----------------------------------------------------------------------------
module rtpl_match (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [31:0]         key,
  input  rtpl_pkg::tbl_rd_t   rd,
  output rtpl_pkg::scan_res_t res
);
  import rtpl_pkg::*;

  logic key_eq;
  logic pfx_eq;
  logic better;

  assign key_eq = rd.slot_valid && (rd.entry.dest == key);
  assign pfx_eq = rd.slot_valid && ((key & rd.entry.mask) == (rd.entry.dest & rd.entry.mask));
  // Longer prefix wins; on equal length the smaller destination wins.
  assign better = !res.best_found
               || (rd.entry.plen > res.best_entry.plen)
               || ((rd.entry.plen == res.best_entry.plen)
                   && (rd.entry.dest < res.best_entry.dest));

  always_ff @(posedge clk) begin
    if (rd.valid) begin
      if (key_eq && !res.exact_found) begin
        res.exact_idx   <= rd.idx;
        res.exact_entry <= rd.entry;
      end
      if (!rd.slot_valid && !res.free_found) begin
        res.free_idx <= rd.idx;
      end
      if (pfx_eq && better) begin
        res.best_entry <= rd.entry;
      end
    end
    if (rst) begin
      res.exact_found <= 1'b0;
      res.free_found  <= 1'b0;
      res.best_found  <= 1'b0;
    end else if (start) begin
      res.exact_found <= 1'b0;
      res.free_found  <= 1'b0;
      res.best_found  <= 1'b0;
    end else if (rd.valid) begin
      if (key_eq && !res.exact_found) begin
        res.exact_found <= 1'b1;
      end
      if (!rd.slot_valid && !res.free_found) begin
        res.free_found <= 1'b1;
      end
      if (pfx_eq && better) begin
        res.best_found <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/route_table_prefix_lookup.sv =====
// ----------------------------------------------------------------------------
// route_table_prefix_lookup
// IPv4 route table with add, remove, clear and longest prefix lookup.
//
//   channel  signals                      role
//   req      req_valid, req_ready, req    one operation in
//   rsp      rsp_valid, rsp_ready, rsp    one result out per operation
//
// Add, remove and lookup scan every slot through the one memory read port,
// one slot a cycle, then step through ST_DRAIN, ST_APPLY and ST_RESP.
// Clear skips the scan and ST_DRAIN. One transaction is in flight at a time.
// Reset empties the table at once through the valid bits; no clearing pass.
// A result held by rsp_ready low does not stop the next request being taken;
// that request waits at its final step until the result register frees up.
// ----------------------------------------------------------------------------
module route_table_prefix_lookup (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  rtpl_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output rtpl_pkg::rsp_t rsp
);
  import rtpl_pkg::*;

  state_e    state;
  state_e    state_next;
  idx_t      cnt;
  req_t      req_q;
  tbl_cmd_t  cmd;
  tbl_rd_t   rd;
  scan_res_t res;
  rsp_t      rsp_next;
  logic      accept;
  logic      rsp_load;
  logic      scan_last;

  assign accept    = req_valid && req_ready;
  assign scan_last = (cnt == idx_t'(TABLE_ENTRIES - 1));

  rtpl_table u_table (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rd  (rd)
  );

  rtpl_match u_match (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .key   (req_q.address),
    .rd    (rd),
    .res   (res)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (req.mode == MODE_CLEAR) ? ST_APPLY : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_APPLY;
      ST_APPLY: state_next = ST_RESP;
      ST_RESP: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    req_ready        = 1'b0;
    rsp_load         = 1'b0;
    cmd              = '0;
    cmd.rd_addr      = cnt;
    cmd.wr_data.dest     = req_q.address;
    cmd.wr_data.mask     = req_q.entry_mask;
    cmd.wr_data.next_hop = req_q.entry_next_hop;
    cmd.wr_data.itf      = req_q.entry_interface;
    cmd.wr_data.plen     = lead_ones(req_q.entry_mask);
    cmd.wr_addr      = res.exact_found ? res.exact_idx : res.free_idx;
    cmd.clr_addr     = res.exact_idx;
    unique case (state)
      ST_IDLE:  req_ready = 1'b1;
      ST_SCAN:  cmd.rd_en = 1'b1;
      ST_DRAIN: ;
      ST_APPLY: begin
        unique case (req_q.mode)
          MODE_ADD:    cmd.wr_en   = res.exact_found || res.free_found;
          MODE_REMOVE: cmd.clr_en  = res.exact_found;
          MODE_CLEAR:  cmd.clr_all = 1'b1;
          MODE_LOOKUP: ;
          default: ;
        endcase
      end
      ST_RESP:  rsp_load = !rsp_valid || rsp_ready;
      default: ;
    endcase
  end

  // Result of the finished transaction
  always_comb begin
    rsp_next        = '0;
    rsp_next.status = STATUS_DONE;
    unique case (req_q.mode)
      MODE_ADD: begin
        if (!res.exact_found && !res.free_found) begin
          rsp_next.status = STATUS_FULL;
        end
      end
      MODE_REMOVE, MODE_CLEAR: ;
      MODE_LOOKUP: begin
        if (res.exact_found) begin
          rsp_next.hit                 = 1'b1;
          rsp_next.exact_hit           = 1'b1;
          rsp_next.found_dest          = res.exact_entry.dest;
          rsp_next.found_mask          = res.exact_entry.mask;
          rsp_next.found_next_hop      = res.exact_entry.next_hop;
          rsp_next.found_interface     = res.exact_entry.itf;
          rsp_next.found_prefix_length = res.exact_entry.plen;
        end else if (res.best_found) begin
          rsp_next.hit                 = 1'b1;
          rsp_next.found_dest          = res.best_entry.dest;
          rsp_next.found_mask          = res.best_entry.mask;
          rsp_next.found_next_hop      = res.best_entry.next_hop;
          rsp_next.found_interface     = res.best_entry.itf;
          rsp_next.found_prefix_length = res.best_entry.plen;
        end else begin
          rsp_next.status = STATUS_NO_ROUTE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt <= '0;
      end else if (state == ST_SCAN) begin
        cnt <= cnt + 1'b1;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  // Only one transaction is in flight.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req_ready)
    else $error("request taken while another is in flight");

  // A returned route always comes with a done status.
  a_hit_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.hit |-> rsp.status == STATUS_DONE)
    else $error("hit with non-done status");

  // An exact hit is always a hit, and its destination is the looked-up key.
  a_exact_key: assert property (@(posedge clk) disable iff (rst)
    rsp_load && rsp_next.exact_hit |-> rsp_next.hit && rsp_next.found_dest == req_q.address)
    else $error("exact hit does not match the key");

  // Prefix length never exceeds the mask width.
  a_plen_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.found_prefix_length <= 6'd32)
    else $error("prefix length out of range");

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the route table prefix lookup block.
// A behavioral route table inside the bench computes the expected response at
// each accepted request. Responses are checked field by field and in order.
// Directed tests cover the empty table, nested prefixes, equal-length ties,
// non-contiguous masks, replace, remove, clear and the full table. Random
// traffic is drawn from a few address clusters so that lookups hit several
// routes at once. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rtpl_pkg::*;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  route_table_prefix_lookup uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // Bench copy of the route table
  logic        route_used [TABLE_ENTRIES];
  logic [31:0] route_dest [TABLE_ENTRIES];
  logic [31:0] route_mask [TABLE_ENTRIES];
  logic [31:0] route_hop  [TABLE_ENTRIES];
  logic [3:0]  route_itf  [TABLE_ENTRIES];

  // Address bytes that random routes and lookups are built from
  logic [7:0]  cluster_byte [4][8];

  rsp_t expected_rsp_q [$];
  bit   quiet_mode;
  int   mismatches;
  int   results_seen;
  int   n_add, n_full, n_remove, n_clear, n_lookup, n_exact, n_prefix, n_miss;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("Timeout with %0d responses outstanding", expected_rsp_q.size());
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Route table prediction
  // --------------------------------------------------------------------------
  function automatic logic [5:0] count_prefix_bits(input logic [31:0] m);
    int n;
    n = 0;
    while (n < 32 && m[31-n]) n++;
    return 6'(n);
  endfunction

  function automatic int find_route(input logic [31:0] key);
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (route_used[k] && route_dest[k] == key) return k;
    end
    return -1;
  endfunction

  function automatic rsp_t apply_route_op(input req_t op);
    rsp_t       r;
    int         sel;
    int         k;
    logic [5:0] plen;
    logic [5:0] best;
    r    = '0;
    sel  = -1;
    best = '0;
    case (op.mode)
      MODE_ADD: begin
        n_add++;
        k = find_route(op.address);
        if (k < 0) begin
          for (int j = 0; j < TABLE_ENTRIES; j++) begin
            if (!route_used[j]) begin
              k = j;
              break;
            end
          end
        end
        if (k < 0) begin
          r.status = STATUS_FULL;
          n_full++;
        end else begin
          route_used[k] = 1'b1;
          route_dest[k] = op.address;
          route_mask[k] = op.entry_mask;
          route_hop[k]  = op.entry_next_hop;
          route_itf[k]  = op.entry_interface;
        end
      end
      MODE_REMOVE: begin
        n_remove++;
        k = find_route(op.address);
        if (k >= 0) route_used[k] = 1'b0;
      end
      MODE_CLEAR: begin
        n_clear++;
        for (int j = 0; j < TABLE_ENTRIES; j++) route_used[j] = 1'b0;
      end
      default: begin
        n_lookup++;
        sel = find_route(op.address);
        if (sel >= 0) begin
          r.exact_hit = 1'b1;
          n_exact++;
        end else begin
          for (int j = 0; j < TABLE_ENTRIES; j++) begin
            if (route_used[j] &&
                (op.address & route_mask[j]) == (route_dest[j] & route_mask[j])) begin
              plen = count_prefix_bits(route_mask[j]);
              if (sel < 0 || plen > best ||
                  (plen == best && route_dest[j] < route_dest[sel])) begin
                sel  = j;
                best = plen;
              end
            end
          end
          if (sel >= 0) n_prefix++;
        end
        if (sel < 0) begin
          r.status = STATUS_NO_ROUTE;
          n_miss++;
        end else begin
          r.hit                 = 1'b1;
          r.found_dest          = route_dest[sel];
          r.found_mask          = route_mask[sel];
          r.found_next_hop      = route_hop[sel];
          r.found_interface     = route_itf[sel];
          r.found_prefix_length = count_prefix_bits(route_mask[sel]);
        end
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (quiet_mode || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(40, 160);
  endfunction

  function automatic req_t route_req(input mode_e m, input logic [31:0] addr,
                                     input logic [31:0] mask, input logic [31:0] hop,
                                     input logic [3:0] itf);
    req_t op;
    op.mode            = m;
    op.address         = addr;
    op.entry_mask      = mask;
    op.entry_next_hop  = hop;
    op.entry_interface = itf;
    return op;
  endfunction

  // Enter at a rising edge; hold valid with a new payload when there is no gap.
  task automatic send_route_op(input req_t op);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= op;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    expected_rsp_q.insert(expected_rsp_q.size(), apply_route_op(op));
  endtask

  // Drop valid and hold off until every pending response has arrived.
  task automatic wait_for_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Response side
  // --------------------------------------------------------------------------
  initial begin : rsp_stall
    int hold;
    int r;
    rsp_ready = 1'b0;
    hold      = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (quiet_mode) begin
        rsp_ready <= 1'b1;
      end else begin
        r = $urandom_range(99);
        if (r < 60) begin
          rsp_ready <= 1'b1;
          hold = $urandom_range(0, 30);
        end else if (r < 95) begin
          rsp_ready <= 1'b0;
          hold = $urandom_range(0, 3);
        end else begin
          rsp_ready <= 1'b0;
          hold = $urandom_range(20, 150);
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch on response %0d, %s: expected 0x%0h, got 0x%0h",
                 results_seen, name, want, got);
    end
  endtask

  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Response %0d arrived with nothing pending: %p", results_seen, rsp);
      end else begin
        want = expected_rsp_q.pop_front();
        check_field("status",              32'(rsp.status),         32'(want.status));
        check_field("hit",                 32'(rsp.hit),            32'(want.hit));
        check_field("exact_hit",           32'(rsp.exact_hit),      32'(want.exact_hit));
        check_field("found_dest",          rsp.found_dest,          want.found_dest);
        check_field("found_mask",          rsp.found_mask,          want.found_mask);
        check_field("found_next_hop",      rsp.found_next_hop,      want.found_next_hop);
        check_field("found_interface",     32'(rsp.found_interface),
                    32'(want.found_interface));
        check_field("found_prefix_length", 32'(rsp.found_prefix_length),
                    32'(want.found_prefix_length));
      end
      results_seen++;
    end
  end

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------
  task automatic test_empty_table();
    send_route_op(route_req(MODE_LOOKUP, 32'h0000_0000, '0, '0, 4'h0));
    send_route_op(route_req(MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF));
    send_route_op(route_req(MODE_REMOVE, 32'h0A00_0001, '0, '0, 4'h0));
    send_route_op(route_req(MODE_CLEAR, '0, '0, '0, 4'h0));
  endtask

  task automatic test_prefix_match();
    send_route_op(route_req(MODE_ADD, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 4'hF));
    send_route_op(route_req(MODE_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE, 4'h1));
    send_route_op(route_req(MODE_ADD, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_00FE, 4'h2));
    send_route_op(route_req(MODE_ADD, 32'h0A01_0200, 32'hFFFF_FF00, 32'h0A01_02FE, 4'h3));
    send_route_op(route_req(MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 4'h0));
    send_route_op(route_req(MODE_LOOKUP, 32'h0A01_0203, '0, '0, 4'h0));
    send_route_op(route_req(MODE_LOOKUP, 32'h0A01_FF01, '0, '0, 4'h0));
    send_route_op(route_req(MODE_LOOKUP, 32'h0AFF_FFFF, '0, '0, 4'h0));
    send_route_op(route_req(MODE_LOOKUP, 32'hC0A8_0001, '0, '0, 4'h0));
    send_route_op(route_req(MODE_LOOKUP, 32'hFFFF_FFFF, '0, '0, 4'h0));
    // exact key wins even for the default route
    send_route_op(route_req(MODE_LOOKUP, 32'h0000_0000, '0, '0, 4'h0));
    // equal /8 prefixes: the smallest destination wins, not the lowest slot
    send_route_op(route_req(MODE_ADD, 32'h0A00_0009, 32'hFF00_0000, 32'h0000_0009, 4'h5));
    send_route_op(route_req(MODE_ADD, 32'h0A00_0005, 32'hFF00_0000, 32'h0000_0005, 4'h6));
    send_route_op(route_req(MODE_LOOKUP, 32'h0A7F_0001, '0, '0, 4'h0));
    send_route_op(route_req(MODE_REMOVE, 32'h0A00_0000, '0, '0, 4'h0));
    send_route_op(route_req(MODE_LOOKUP, 32'h0A7F_0001, '0, '0, 4'h0));
    // non-contiguous mask counts only its leading ones
    send_route_op(route_req(MODE_ADD, 32'hC000_0001, 32'hF0F0_F0F0, 32'hC000_00FE, 4'h7));
    send_route_op(route_req(MODE_LOOKUP, 32'hC00F_0F0F, '0, '0, 4'h0));
    send_route_op(route_req(MODE_LOOKUP, 32'hD00F_0F0F, '0, '0, 4'h0));
  endtask

  task automatic test_replace_and_remove();
    send_route_op(route_req(MODE_ADD, 32'h0A01_0000, 32'hFFFF_0000, 32'h1234_5678, 4'h9));
    send_route_op(route_req(MODE_LOOKUP, 32'h0A01_FF01, '0, '0, 4'h0));
    send_route_op(route_req(MODE_REMOVE, 32'h0A01_0200, '0, '0, 4'h0));
    send_route_op(route_req(MODE_LOOKUP, 32'h0A01_0203, '0, '0, 4'h0));
    send_route_op(route_req(MODE_REMOVE, 32'h0A01_0200, '0, '0, 4'h0));
    send_route_op(route_req(MODE_CLEAR, '0, '0, '0, 4'h0));
    send_route_op(route_req(MODE_LOOKUP, 32'h0A01_0203, '0, '0, 4'h0));
    send_route_op(route_req(MODE_LOOKUP, 32'h0000_0000, '0, '0, 4'h0));
  endtask

  task automatic test_table_full();
    for (int k = 0; k < TABLE_ENTRIES; k++)
      send_route_op(route_req(MODE_ADD, {16'hC0A8, 8'(k), 8'h01}, 32'hFFFF_FF00,
                              32'(k), 4'(k)));
    // new key refused, existing key still replaced
    send_route_op(route_req(MODE_ADD, 32'hC0A8_FF01, 32'hFFFF_FF00, 32'hDEAD_BEEF, 4'hA));
    send_route_op(route_req(MODE_ADD, 32'hC0A8_0501, 32'hFFFF_FF00, 32'hFEED_0005, 4'hB));
    send_route_op(route_req(MODE_LOOKUP, 32'hC0A8_0577, '0, '0, 4'h0));
    send_route_op(route_req(MODE_LOOKUP, 32'hC0A8_FF01, '0, '0, 4'h0));
    send_route_op(route_req(MODE_REMOVE, 32'hC0A8_0A01, '0, '0, 4'h0));
    send_route_op(route_req(MODE_ADD, 32'hC0A8_FF01, 32'hFFFF_FF00, 32'hDEAD_BEEF, 4'hA));
    send_route_op(route_req(MODE_LOOKUP, 32'hC0A8_FF01, '0, '0, 4'h0));
    send_route_op(route_req(MODE_CLEAR, '0, '0, '0, 4'h0));
  endtask

  // --------------------------------------------------------------------------
  // Random traffic
  // --------------------------------------------------------------------------
  function automatic logic [31:0] cluster_addr();
    return {cluster_byte[0][$urandom_range(3)], cluster_byte[1][$urandom_range(3)],
            cluster_byte[2][$urandom_range(3)], cluster_byte[3][$urandom_range(7)]};
  endfunction

  function automatic logic [31:0] random_route_mask();
    int r;
    int len;
    r = $urandom_range(99);
    if (r < 10) return $urandom();
    if (r < 15) len = 0;
    else if (r < 55) len = 8 * $urandom_range(1, 4);
    else len = $urandom_range(0, 32);
    return ~(32'hFFFF_FFFF >> len);
  endfunction

  function automatic logic [31:0] stored_key_or(input logic [31:0] fallback);
    int start;
    int idx;
    start = $urandom_range(TABLE_ENTRIES - 1);
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      idx = (start + k) % TABLE_ENTRIES;
      if (route_used[idx]) return route_dest[idx];
    end
    return fallback;
  endfunction

  // Mode mix is given per thousand; whatever is left over is lookups.
  task automatic run_random_traffic(input int count, input int add_pm,
                                    input int remove_pm, input int clear_pm);
    req_t op;
    int   sel;
    int   pick;
    for (int b = 0; b < 4; b++)
      for (int v = 0; v < 8; v++) cluster_byte[b][v] = 8'($urandom());
    for (int n = 0; n < count; n++) begin
      sel                = $urandom_range(999);
      pick               = $urandom_range(99);
      op.entry_mask      = random_route_mask();
      op.entry_next_hop  = $urandom();
      op.entry_interface = 4'($urandom_range(15));
      if (sel < add_pm) begin
        op.mode = MODE_ADD;
        if (pick < 25) op.address = stored_key_or(cluster_addr());
        else if (pick < 90) op.address = cluster_addr() & op.entry_mask;
        else if (pick < 95) op.address = cluster_addr();
        else op.address = $urandom();
      end else if (sel < add_pm + remove_pm) begin
        op.mode    = MODE_REMOVE;
        op.address = (pick < 80) ? stored_key_or(cluster_addr()) : cluster_addr();
      end else if (sel < add_pm + remove_pm + clear_pm) begin
        op.mode    = MODE_CLEAR;
        op.address = $urandom();
      end else begin
        op.mode = MODE_LOOKUP;
        if (pick < 20) op.address = stored_key_or(cluster_addr());
        else if (pick < 85) op.address = cluster_addr();
        else op.address = $urandom();
      end
      if ($urandom_range(99) == 0) wait_for_results();
      send_route_op(op);
    end
  endtask

  task automatic test_mixed_traffic();
    run_random_traffic(550, 350, 150, 5);
  endtask

  // few removes, so the table fills and new keys get refused
  task automatic test_fill_pressure();
    run_random_traffic(450, 500, 50, 4);
  endtask

  task automatic test_back_to_back();
    quiet_mode = 1'b1;
    run_random_traffic(150, 350, 100, 5);
    quiet_mode = 1'b0;
  endtask

  task automatic test_churn();
    run_random_traffic(300, 300, 300, 20);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    for (int k = 0; k < TABLE_ENTRIES; k++) route_used[k] = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    wait_for_results();
    test_prefix_match();
    test_replace_and_remove();
    wait_for_results();
    test_table_full();
    test_mixed_traffic();
    test_fill_pressure();
    wait_for_results();
    test_back_to_back();
    test_churn();

    wait_for_results();
    repeat (100) @(posedge clk);

    $display("Ran %0d operations: %0d adds (%0d refused, table full), %0d removes, %0d clears",
             results_seen, n_add, n_full, n_remove, n_clear);
    $display("%0d lookups: %0d exact key, %0d longest prefix, %0d no route; %0d mismatches",
             n_lookup, n_exact, n_prefix, n_miss, mismatches);
    if (mismatches == 0 && expected_rsp_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
